// ===== sv/yrc_pkg.sv =====
// Package: shared types, constants and helper functions of the YUV to RGB565 converter.
package yrc_pkg;

	// Widths of the stream payloads.
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	// Field widths.
	localparam int SAMPLE_W = 8;
	localparam int COORD_W  = 12;
	localparam int DIM_W    = 13;
	localparam int INDEX_W  = 24;
	localparam int PIXEL_W  = 16;
	localparam int ACC_W    = 19;

	// Default saturation limit of the size registers.
	localparam int MAX_DIM_DEF = 4096;

	// Register indexes of the configuration port.
	localparam logic [1:0] CFG_ROTATION   = 2'd0;
	localparam logic [1:0] CFG_SRC_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_SRC_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_DEST_WIDTH = 2'd3;

	// Register reset values.
	localparam logic [DIM_W-1:0] RESET_DIM = 13'd240;

	// BT.601 studio-range kernel coefficients.
	localparam logic signed [11:0] K_Y    = 12'sd298;
	localparam logic signed [11:0] K_RV   = 12'sd409;
	localparam logic signed [11:0] K_GU   = 12'sd100;
	localparam logic signed [11:0] K_GV   = 12'sd208;
	localparam logic signed [11:0] K_BU   = 12'sd516;
	localparam logic signed [9:0]  Y_OFS  = 10'sd16;
	localparam logic signed [ACC_W-1:0] ROUND = 19'sd128;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	// Geometry settings seen by the address pipeline.
	typedef struct packed {
		rot_t             rot;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] wm1;
		logic [DIM_W-1:0] hm1;
	} geom_t;

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_ld_t;

	// Limits a size register to the maximum frame dimension.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W:0] max_dim);
		logic [DIM_W-1:0] r;
		if ({1'b0, v} > max_dim) begin
			r = max_dim[DIM_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Floors the accumulator by 256 and clamps the channel to 0..255.
	function automatic logic [SAMPLE_W-1:0] clamp8(input logic signed [ACC_W-1:0] a);
		logic [SAMPLE_W-1:0] r;
		if (a[ACC_W-1]) begin
			r = '0;
		end else if (a[ACC_W-2:16] != '0) begin
			r = '1;
		end else begin
			r = a[15:8];
		end
		return r;
	endfunction

endpackage

// ===== sv/yrc_color.sv =====
// Three-stage BT.601 YUV to RGB565 color pipeline.
module yrc_color (
	input  logic                           clk,
	input  yrc_pkg::stage_ld_t             ld,
	input  logic [yrc_pkg::SAMPLE_W-1:0]   luma,
	input  logic [yrc_pkg::SAMPLE_W-1:0]   chroma_blue,
	input  logic [yrc_pkg::SAMPLE_W-1:0]   chroma_red,
	output logic [yrc_pkg::PIXEL_W-1:0]    pixel565
);

	logic signed [9:0] yd;
	logic signed [7:0] du;
	logic signed [7:0] dv;

	logic signed [17:0] c_s1;
	logic signed [16:0] rv_s1;
	logic signed [16:0] g_s1;
	logic signed [17:0] bu_s1;

	logic signed [yrc_pkg::ACC_W-1:0] r_s2;
	logic signed [yrc_pkg::ACC_W-1:0] g_s2;
	logic signed [yrc_pkg::ACC_W-1:0] b_s2;

	logic [yrc_pkg::SAMPLE_W-1:0] r8;
	logic [yrc_pkg::SAMPLE_W-1:0] g8;
	logic [yrc_pkg::SAMPLE_W-1:0] b8;

	logic [yrc_pkg::PIXEL_W-1:0] pixel_s3;

	// Subtracting 128 from an unsigned byte is the same as flipping its top bit.
	assign yd = $signed({2'b00, luma}) - yrc_pkg::Y_OFS;
	assign du = $signed({~chroma_blue[7], chroma_blue[6:0]});
	assign dv = $signed({~chroma_red[7], chroma_red[6:0]});

	// Stage 1: the constant products.
	always_ff @(posedge clk) begin
		if (ld.s1) begin
			c_s1  <= 18'(yd) * 18'(yrc_pkg::K_Y);
			rv_s1 <= 17'(dv) * 17'(yrc_pkg::K_RV);
			g_s1  <= 17'(18'sd0 - du * yrc_pkg::K_GU - dv * yrc_pkg::K_GV);
			bu_s1 <= 18'(du) * 18'(yrc_pkg::K_BU);
		end
	end

	// Stage 2: channel sums with rounding.
	always_ff @(posedge clk) begin
		if (ld.s2) begin
			r_s2 <= 19'(c_s1) + 19'(rv_s1) + yrc_pkg::ROUND;
			g_s2 <= 19'(c_s1) + 19'(g_s1) + yrc_pkg::ROUND;
			b_s2 <= 19'(c_s1) + 19'(bu_s1) + yrc_pkg::ROUND;
		end
	end

	assign r8 = yrc_pkg::clamp8(r_s2);
	assign g8 = yrc_pkg::clamp8(g_s2);
	assign b8 = yrc_pkg::clamp8(b_s2);

	// Stage 3: clamp and pack.
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			pixel_s3 <= {r8[7:3], g8[7:2], b8[7:3]};
		end
	end

	assign pixel565 = pixel_s3;

endmodule

// ===== sv/yrc_addr.sv =====
// Three-stage rotated destination index pipeline.
module yrc_addr (
	input  logic                          clk,
	input  yrc_pkg::stage_ld_t            ld,
	input  yrc_pkg::geom_t                geom,
	input  logic [yrc_pkg::COORD_W-1:0]   col,
	input  logic [yrc_pkg::COORD_W-1:0]   row,
	output logic [yrc_pkg::INDEX_W-1:0]   dest_index,
	output logic                          out_of_range
);

	logic [yrc_pkg::DIM_W-1:0] dx;
	logic [yrc_pkg::DIM_W-1:0] dy;
	logic                      oor;

	logic [yrc_pkg::DIM_W-1:0]   dx_s1;
	logic [yrc_pkg::DIM_W-1:0]   dy_s1;
	logic                        oor_s1;
	logic [yrc_pkg::DIM_W-1:0]   dx_s2;
	logic [yrc_pkg::INDEX_W-1:0] prod_s2;
	logic                        oor_s2;
	logic [yrc_pkg::INDEX_W-1:0] idx_s3;
	logic                        oor_s3;
	logic [2*yrc_pkg::DIM_W-1:0] prod_full;

	assign oor = ({1'b0, col} >= geom.w) || ({1'b0, row} >= geom.h);

	// The differences only matter for in-range pixels, where they cannot wrap.
	always_comb begin
		unique case (geom.rot)
			yrc_pkg::ROT_0: begin
				dx = {1'b0, col};
				dy = {1'b0, row};
			end
			yrc_pkg::ROT_90: begin
				dx = geom.hm1 - {1'b0, row};
				dy = {1'b0, col};
			end
			yrc_pkg::ROT_180: begin
				dx = geom.wm1 - {1'b0, col};
				dy = geom.hm1 - {1'b0, row};
			end
			yrc_pkg::ROT_270: begin
				dx = {1'b0, row};
				dy = geom.wm1 - {1'b0, col};
			end
			default: begin
				dx = {1'b0, col};
				dy = {1'b0, row};
			end
		endcase
	end

	assign prod_full = dy_s1 * geom.dw;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			dx_s1  <= dx;
			dy_s1  <= dy;
			oor_s1 <= oor;
		end
		if (ld.s2) begin
			dx_s2   <= dx_s1;
			prod_s2 <= prod_full[yrc_pkg::INDEX_W-1:0];
			oor_s2  <= oor_s1;
		end
		if (ld.s3) begin
			idx_s3 <= oor_s2 ? '0 : prod_s2 + yrc_pkg::INDEX_W'(dx_s2);
			oor_s3 <= oor_s2;
		end
	end

	assign dest_index   = idx_s3;
	assign out_of_range = oor_s3;

endmodule

// ===== sv/yuv_to_rgb565_rotating_converter_unit.sv =====
// Top level: YUV to RGB565 converter with rotated destination addressing.
// An accepted beat moves through register stages 1, 2 and 3 and is offered on the master side from stage 3.
// Throughput: one beat per cycle; the three register stages hold only while the
// master side stalls, and bubbles in the pipeline are squeezed out during a stall.
// Reset (arst_n low, asynchronous) empties the pipeline and returns the registers to
// rotation 90 degrees and 240 x 240 source and 240-pixel destination rows.
module yuv_to_rgb565_rotating_converter_unit #(
	parameter int MAX_DIM = yrc_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream. tdata from bit 0: luma[7:0], chroma_blue[15:8], chroma_red[23:16],
	// col[35:24], row[47:36].
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [yrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// Output stream. tdata from bit 0: pixel565[15:0], dest_index[39:16],
	// out_of_range[40], zero fill[47:41].
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [yrc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_addr,
	input  logic [yrc_pkg::DIM_W-1:0]         cfg_wdata
);

	localparam logic [yrc_pkg::DIM_W:0] MaxDimW = (yrc_pkg::DIM_W+1)'(MAX_DIM);
	localparam logic [yrc_pkg::DIM_W-1:0] ResetSat = yrc_pkg::sat_dim(yrc_pkg::RESET_DIM,
		MaxDimW);

	// Configuration registers. The size registers are kept already saturated, and the
	// "minus one" copies used by the rotations are kept beside them so that the first
	// stage only has one subtract per axis.
	yrc_pkg::rot_t                rot_q;
	logic [yrc_pkg::DIM_W-1:0]    w_q;
	logic [yrc_pkg::DIM_W-1:0]    h_q;
	logic [yrc_pkg::DIM_W-1:0]    dw_q;
	logic [yrc_pkg::DIM_W-1:0]    wm1_q;
	logic [yrc_pkg::DIM_W-1:0]    hm1_q;
	logic [yrc_pkg::DIM_W-1:0]    wr_sat;
	yrc_pkg::geom_t               geom;

	assign wr_sat = yrc_pkg::sat_dim(cfg_wdata, MaxDimW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= yrc_pkg::ROT_90;
			w_q   <= ResetSat;
			h_q   <= ResetSat;
			dw_q  <= ResetSat;
			wm1_q <= ResetSat - 1'b1;
			hm1_q <= ResetSat - 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				yrc_pkg::CFG_ROTATION: begin
					rot_q <= yrc_pkg::rot_t'(cfg_wdata[1:0]);
				end
				yrc_pkg::CFG_SRC_WIDTH: begin
					w_q   <= wr_sat;
					wm1_q <= wr_sat - 1'b1;
				end
				yrc_pkg::CFG_SRC_HEIGHT: begin
					h_q   <= wr_sat;
					hm1_q <= wr_sat - 1'b1;
				end
				yrc_pkg::CFG_DEST_WIDTH: begin
					dw_q <= wr_sat;
				end
				default: begin
				end
			endcase
		end
	end

	assign geom = '{rot: rot_q, w: w_q, h: h_q, dw: dw_q, wm1: wm1_q, hm1: hm1_q};

	// Pipeline control. Each stage loads when it is empty or when the stage after it
	// loads, so the last stage doubles as the output register and a stall on the
	// master side only holds the stages that actually carry a beat.
	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               ld_s1;
	logic               ld_s2;
	logic               ld_s3;
	yrc_pkg::stage_ld_t ld;

	assign ld_s3 = !v_s3 || m_axis_tready;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;
	assign ld    = '{s1: ld_s1, s2: ld_s2, s3: ld_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign s_axis_tready = ld_s1;
	assign m_axis_tvalid = v_s3;

	logic [yrc_pkg::PIXEL_W-1:0] pixel565;
	logic [yrc_pkg::INDEX_W-1:0] dest_index;
	logic                        out_of_range;

	// Color path: products, sums, then clamp and pack.
	yrc_color u_color (
		.clk         (clk),
		.ld          (ld),
		.luma        (s_axis_tdata[7:0]),
		.chroma_blue (s_axis_tdata[15:8]),
		.chroma_red  (s_axis_tdata[23:16]),
		.pixel565    (pixel565)
	);

	// Address path: range check and rotation, multiply by the row width, then add.
	yrc_addr u_addr (
		.clk          (clk),
		.ld           (ld),
		.geom         (geom),
		.col          (s_axis_tdata[35:24]),
		.row          (s_axis_tdata[47:36]),
		.dest_index   (dest_index),
		.out_of_range (out_of_range)
	);

	assign m_axis_tdata = {7'd0, out_of_range, dest_index, pixel565};

	// A pixel outside the source never carries a nonzero index.
	a_oor_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tdata[39:16] == '0)
		else $error("out-of-range beat with nonzero destination index");

	// A beat in the first stage moves on whenever the second stage loads.
	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ld_s2 |=> v_s2)
		else $error("beat lost between the first and second stage");

	// With every stage full and the output stalled, no new beat is taken.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while the pipeline is full and stalled");

	// An accepted beat sits in the first stage at the next edge.
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted beat did not enter the first stage");

endmodule

// ===== test/tb_yuv_to_rgb565_rotating_converter_unit.sv =====
`timescale 1ns / 100ps
// Testbench of the YUV to RGB565 converter with rotated destination addressing.
module tb_yuv_to_rgb565_rotating_converter_unit;

	localparam int DIM_CAP = yrc_pkg::MAX_DIM_DEF;

	// One input beat as it sits in s_axis_tdata, luma in the lowest bits.
	typedef struct packed {
		logic [yrc_pkg::COORD_W-1:0]  row;
		logic [yrc_pkg::COORD_W-1:0]  col;
		logic [yrc_pkg::SAMPLE_W-1:0] chroma_red;
		logic [yrc_pkg::SAMPLE_W-1:0] chroma_blue;
		logic [yrc_pkg::SAMPLE_W-1:0] luma;
	} pixel_in_t;

	// One output beat as it sits in m_axis_tdata, pixel565 in the lowest bits.
	typedef struct packed {
		logic [6:0]                  fill;
		logic                        out_of_range;
		logic [yrc_pkg::INDEX_W-1:0] dest_index;
		logic [yrc_pkg::PIXEL_W-1:0] pixel565;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [yrc_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [yrc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = yrc_pkg::CFG_ROTATION;
	logic [yrc_pkg::DIM_W-1:0] cfg_wdata = '0;

	// The testbench's own copy of the geometry registers, starting at their reset values.
	yrc_pkg::rot_t             cur_rot = yrc_pkg::ROT_90;
	logic [yrc_pkg::DIM_W-1:0] cur_src_w = 13'd240;
	logic [yrc_pkg::DIM_W-1:0] cur_src_h = 13'd240;
	logic [yrc_pkg::DIM_W-1:0] cur_dest_w = 13'd240;

	pixel_in_t pending_pixels[$];
	result_t   expected_results[$];
	int        pixels_in_flight = 0;
	int        mismatch_count = 0;
	int        idle_pct = 0;
	int        src_gap = 0;
	int        sink_stall = 0;
	result_t   got_result;
	result_t   want_result;

	yuv_to_rgb565_rotating_converter_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Size registers larger than the frame limit behave as the limit itself.
	function automatic int dim_limit(input logic [yrc_pkg::DIM_W-1:0] v);
		int r;
		r = int'(v);
		if (r > DIM_CAP) begin
			r = DIM_CAP;
		end
		return r;
	endfunction

	// Floor by 256, then clamp the channel into 0..255.
	function automatic logic [yrc_pkg::SAMPLE_W-1:0] channel_clamp(input int acc);
		int q;
		if (acc < 0) begin
			return '0;
		end
		q = acc >>> 8;
		if (q > 255) begin
			q = 255;
		end
		return q[yrc_pkg::SAMPLE_W-1:0];
	endfunction

	// Color conversion plus rotated addressing of one pixel under the current geometry.
	function automatic result_t predict_pixel(input pixel_in_t p);
		int yv, du, dv, c;
		logic [yrc_pkg::SAMPLE_W-1:0] r, g, b;
		int w, h, dw, x, y, dx, dy;
		longint lin;
		result_t res;
		yv = int'(p.luma);
		du = int'(p.chroma_blue);
		dv = int'(p.chroma_red);
		du = du - 128;
		dv = dv - 128;
		c = 298 * (yv - 16);
		r = channel_clamp(c + 409 * dv + 128);
		g = channel_clamp(c - 100 * du - 208 * dv + 128);
		b = channel_clamp(c + 516 * du + 128);
		res = '0;
		res.pixel565 = {r[7:3], g[7:2], b[7:3]};
		w = dim_limit(cur_src_w);
		h = dim_limit(cur_src_h);
		dw = dim_limit(cur_dest_w);
		x = int'(p.col);
		y = int'(p.row);
		// A zero size makes every coordinate fall outside, which this compare covers.
		res.out_of_range = (x >= w) || (y >= h);
		if (!res.out_of_range) begin
			case (cur_rot)
				yrc_pkg::ROT_90: begin
					dx = h - 1 - y;
					dy = x;
				end
				yrc_pkg::ROT_180: begin
					dx = w - 1 - x;
					dy = h - 1 - y;
				end
				yrc_pkg::ROT_270: begin
					dx = y;
					dy = w - 1 - x;
				end
				default: begin
					dx = x;
					dy = y;
				end
			endcase
			lin = longint'(dy) * longint'(dw) + longint'(dx);
			res.dest_index = lin[yrc_pkg::INDEX_W-1:0];
		end
		return res;
	endfunction

	// Source side: beats come from the pending queue, with random bursts of idle cycles.
	// The expectation of a beat is formed at the edge that accepts it.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results = {expected_results,
					predict_pixel(pixel_in_t'(s_axis_tdata))};
			end
			// A beat on offer is held until the block takes it.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pixels.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if ($urandom_range(99) < idle_pct) begin
					// Start a burst of idle cycles, this one included.
					src_gap = $urandom_range(16);
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata <= pending_pixels.pop_front();
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	// Sink side: every accepted result beat is checked against the oldest expectation,
	// and tready drops in random stall bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_result = result_t'(m_axis_tdata);
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: result beat with nothing expected: pixel565=%h idx=%0d oor=%b",
							$realtime, got_result.pixel565, got_result.dest_index,
							got_result.out_of_range);
					end
				end else begin
					want_result = expected_results.pop_front();
					pixels_in_flight--;
					if (got_result.pixel565 !== want_result.pixel565 ||
						got_result.dest_index !== want_result.dest_index ||
						got_result.out_of_range !== want_result.out_of_range) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: mismatch: pixel565 %h/%h idx %0d/%0d oor %b/%b (exp/got)",
								$realtime, want_result.pixel565, got_result.pixel565,
								want_result.dest_index, got_result.dest_index,
								want_result.out_of_range, got_result.out_of_range);
						end
					end
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < idle_pct) begin
				sink_stall = $urandom_range(16);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// One register write per clock; the block takes it at the following edge.
	task automatic write_reg(input logic [1:0] idx, input logic [yrc_pkg::DIM_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
	endtask

	// Writes all four registers. The rotation write carries random upper bits, which
	// the block must drop.
	task automatic set_geometry(input yrc_pkg::rot_t rot,
		input logic [yrc_pkg::DIM_W-1:0] w, input logic [yrc_pkg::DIM_W-1:0] h,
		input logic [yrc_pkg::DIM_W-1:0] dw);
		logic [yrc_pkg::DIM_W-3:0] junk;
		junk = (yrc_pkg::DIM_W-2)'($urandom);
		write_reg(yrc_pkg::CFG_ROTATION, {junk, rot});
		write_reg(yrc_pkg::CFG_SRC_WIDTH, w);
		write_reg(yrc_pkg::CFG_SRC_HEIGHT, h);
		write_reg(yrc_pkg::CFG_DEST_WIDTH, dw);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_rot = rot;
		cur_src_w = w;
		cur_src_h = h;
		cur_dest_w = dw;
	endtask

	task automatic queue_pixel(input int luma, input int cb, input int cr, input int col,
		input int row);
		pixel_in_t p;
		p.luma = yrc_pkg::SAMPLE_W'(luma);
		p.chroma_blue = yrc_pkg::SAMPLE_W'(cb);
		p.chroma_red = yrc_pkg::SAMPLE_W'(cr);
		p.col = yrc_pkg::COORD_W'(col);
		p.row = yrc_pkg::COORD_W'(row);
		pending_pixels = {pending_pixels, p};
		pixels_in_flight++;
	endtask

	// Mostly coordinates inside the current source size, the rest anywhere in 12 bits.
	function automatic int pick_coord(input logic [yrc_pkg::DIM_W-1:0] size);
		int lim;
		lim = dim_limit(size);
		if (lim > 0 && $urandom_range(4) != 0) begin
			return $urandom_range(lim - 1);
		end
		return $urandom_range(4095);
	endfunction

	// Size register values: mostly small frames, some large, some beyond the limit, a few zero.
	function automatic logic [yrc_pkg::DIM_W-1:0] random_dim();
		int k;
		k = $urandom_range(99);
		if (k < 5) begin
			return '0;
		end else if (k < 60) begin
			return yrc_pkg::DIM_W'($urandom_range(64, 1));
		end else if (k < 85) begin
			return yrc_pkg::DIM_W'($urandom_range(DIM_CAP, 1));
		end
		return yrc_pkg::DIM_W'($urandom_range(8191, DIM_CAP + 1));
	endfunction

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++) begin
			queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
				pick_coord(cur_src_w), pick_coord(cur_src_h));
		end
	endtask

	// Returns once every queued pixel has come back through the sink side.
	task automatic wait_drained();
		while (pixels_in_flight != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 20;

		// Reset geometry: 90 degrees, 240 x 240 source, 240-pixel rows. Colors cover
		// black, white, both clamp directions and an ordinary hue; coordinates cover the
		// corners and both kinds of out-of-range pixel.
		queue_pixel(16, 128, 128, 0, 0);
		queue_pixel(235, 128, 128, 239, 239);
		queue_pixel(255, 0, 0, 239, 0);
		queue_pixel(255, 255, 255, 0, 239);
		queue_pixel(0, 0, 0, 240, 0);
		queue_pixel(0, 255, 255, 0, 240);
		queue_pixel(128, 0, 255, 4095, 4095);
		queue_pixel(81, 90, 240, 100, 50);
		wait_drained();

		// Largest frame without rotation: the far corner gives the top 24-bit index.
		set_geometry(yrc_pkg::ROT_0, 13'd4096, 13'd4096, 13'd4096);
		queue_pixel(255, 255, 0, 4095, 4095);
		queue_pixel(0, 255, 0, 0, 0);
		queue_pixel(16, 0, 255, 4095, 0);
		queue_pixel(200, 128, 128, 0, 4095);
		queue_random(5);
		wait_drained();

		// 180 degrees, width register beyond the limit, single-row source, zero row width.
		set_geometry(yrc_pkg::ROT_180, 13'd8191, 13'd1, 13'd0);
		queue_pixel(90, 60, 200, 17, 0);
		queue_pixel(90, 60, 200, 5, 1);
		queue_pixel(240, 16, 240, 4095, 0);
		queue_random(5);
		wait_drained();

		// 270 degrees with a zero-width source, so nothing lies inside it.
		set_geometry(yrc_pkg::ROT_270, 13'd0, 13'd100, 13'd8191);
		queue_pixel(100, 100, 100, 0, 0);
		queue_random(5);
		wait_drained();

		// 90 degrees on a one-column source with one-pixel destination rows.
		set_geometry(yrc_pkg::ROT_90, 13'd1, 13'd4096, 13'd1);
		queue_pixel(50, 200, 30, 0, 4095);
		queue_pixel(50, 200, 30, 1, 0);
		queue_random(5);
		wait_drained();

		// Random geometries. Some phases run without idling so that stretches of full
		// throughput occur, and the final phase has none at all.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7 || ph % 3 == 0) begin
				idle_pct = 0;
			end else begin
				idle_pct = 25;
			end
			set_geometry(yrc_pkg::rot_t'(2'($urandom_range(3))), random_dim(), random_dim(),
				random_dim());
			queue_random(60);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_yuv_to_rgb565_rotating_converter_unit: PASS");
		end else begin
			$display("tb_yuv_to_rgb565_rotating_converter_unit: FAIL");
		end
		$finish;
	end

	// A correct run takes well under a tenth of this.
	initial begin
		#5000000;
		$display("tb_yuv_to_rgb565_rotating_converter_unit: FAIL");
		$finish;
	end

endmodule
